FILE: hw/rtl/lexer_token_scanner_top_assert.svh
// Assertion macros shared by the lexer token scanner RTL.
`ifndef LEXER_TOKEN_SCANNER_TOP_ASSERT_SVH
`define LEXER_TOKEN_SCANNER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define LTS_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lexer token scanner assertion failed");
// Consequent that must hold in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer token scanner assertion failed");
`else
`define LTS_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define LTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/lts_pkg.sv
// Types, codes, character constants and classifiers for the lexer token scanner.
package lts_pkg;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_BLOCK   = 3'd3,
        MODE_NAME    = 3'd4,
        MODE_HALTED  = 3'd5
    } mode_t;

    localparam logic [2:0] KIND_NAME_CHAR = 3'd0;
    localparam logic [2:0] KIND_NAME_END  = 3'd1;
    localparam logic [2:0] KIND_OPERATOR  = 3'd2;
    localparam logic [2:0] KIND_QUOTE     = 3'd3;
    localparam logic [2:0] KIND_EOI       = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL = 2'd1;
    localparam logic [1:0] ERR_SLASH   = 2'd2;
    localparam logic [1:0] ERR_UNTERM  = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One result word as held in the output slots.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] chr;
        logic [1:0] err;
        logic       last;
    } res_t;

    // Outcome of scanning one byte between tokens.
    typedef struct packed {
        mode_t mode;
        logic  emit;
        res_t  res;
    } between_t;

    function automatic logic is_letter_like(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDER) ||
               (c == CH_DOLLAR);
    endfunction

    function automatic logic is_name_part(input logic [7:0] c);
        return is_letter_like(c) || (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_LF, CH_CR, CH_TAB};
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c inside {CH_COLON, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
                         CH_COMMA, CH_EQUAL, CH_DOT, CH_SEMI};
    endfunction

    function automatic res_t make_res(input logic [2:0] kind, input logic [7:0] chr,
                                      input logic [1:0] err);
        res_t r;
        r.kind = kind;
        r.chr  = chr;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

    // Classify a byte seen while between tokens.
    function automatic between_t scan_between(input logic [7:0] c);
        between_t b;
        b.mode = MODE_BETWEEN;
        b.emit = 1'b0;
        b.res  = make_res(KIND_NAME_CHAR, CH_NUL, ERR_NONE);
        if (is_blank(c)) begin
            b.emit = 1'b0;
        end else if (c == CH_SLASH) begin
            b.mode = MODE_SLASH;
        end else if (is_letter_like(c)) begin
            b.mode = MODE_NAME;
            b.emit = 1'b1;
            b.res  = make_res(KIND_NAME_CHAR, c, ERR_NONE);
        end else if (is_operator(c)) begin
            b.emit = 1'b1;
            b.res  = make_res(KIND_OPERATOR, c, ERR_NONE);
        end else if (c == CH_QUOTE) begin
            b.emit = 1'b1;
            b.res  = make_res(KIND_QUOTE, c, ERR_NONE);
        end else begin
            b.mode = MODE_HALTED;
            b.emit = 1'b1;
            b.res  = make_res(KIND_ERROR, c, ERR_ILLEGAL);
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/lexer_token_scanner_top.sv
// Top level of the lexer token scanner: input register, scan logic, two result slots.
// A result word passes through the input register and a result slot before it is offered on the m_ side.
// Throughput: one byte per cycle while m_tready is held; a byte that yields two words holds
// the input longer, since the two result slots must both be free or emptying before a byte is scanned.
// Reset (aresetn low, synchronous) empties the slots and returns the scanner to between
// tokens; after an error or end of input it emits nothing until the next reset.
`include "lexer_token_scanner_top_assert.svh"

module lexer_token_scanner_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] character, [9:8] error_code, [15:10] zero
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import lts_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    mode_t      mode_reg, mode_next;
    logic       star_reg, star_next;

    res_t       slot0_reg, slot1_reg;
    logic [1:0] cnt_reg;

    logic       pop;
    logic       adv;
    logic [1:0] n_res;
    res_t       r0, r1;
    between_t   sb;

    // Handshake: scan a byte only when both slots will be free this cycle.
    assign pop      = m_tvalid && m_tready;
    assign adv      = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign s_tready = !in_valid_reg || adv;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
    end

    // Scan logic: next mode, star flag and up to two result words.
    always_comb begin
        mode_next = mode_reg;
        star_next = star_reg;
        n_res     = 2'd0;
        r0        = make_res(KIND_NAME_CHAR, CH_NUL, ERR_NONE);
        r1        = make_res(KIND_NAME_CHAR, CH_NUL, ERR_NONE);
        sb        = scan_between(in_byte_reg);
        case (mode_reg)
            MODE_BETWEEN: begin
                if (in_eoi_reg) begin
                    mode_next = MODE_HALTED;
                    n_res     = 2'd1;
                    r0        = make_res(KIND_EOI, CH_NUL, ERR_NONE);
                end else begin
                    mode_next = sb.mode;
                    n_res     = {1'b0, sb.emit};
                    r0        = sb.res;
                end
            end
            MODE_SLASH: begin
                if (!in_eoi_reg && (in_byte_reg == CH_SLASH)) begin
                    mode_next = MODE_LINE;
                end else if (!in_eoi_reg && (in_byte_reg == CH_STAR)) begin
                    mode_next = MODE_BLOCK;
                    star_next = 1'b0;
                end else begin
                    mode_next = MODE_HALTED;
                    n_res     = 2'd1;
                    r0        = make_res(KIND_ERROR, CH_SLASH, ERR_SLASH);
                end
            end
            MODE_LINE: begin
                if (in_eoi_reg) begin
                    mode_next = MODE_HALTED;
                    n_res     = 2'd1;
                    r0        = make_res(KIND_EOI, CH_NUL, ERR_NONE);
                end else if ((in_byte_reg == CH_LF) || (in_byte_reg == CH_CR)) begin
                    mode_next = MODE_BETWEEN;
                end
            end
            MODE_BLOCK: begin
                if (in_eoi_reg) begin
                    mode_next = MODE_HALTED;
                    star_next = 1'b0;
                    n_res     = 2'd1;
                    r0        = make_res(KIND_ERROR, CH_NUL, ERR_UNTERM);
                end else if (star_reg && (in_byte_reg == CH_SLASH)) begin
                    mode_next = MODE_BETWEEN;
                    star_next = 1'b0;
                end else begin
                    star_next = (in_byte_reg == CH_STAR);
                end
            end
            MODE_NAME: begin
                if (!in_eoi_reg && is_name_part(in_byte_reg)) begin
                    n_res = 2'd1;
                    r0    = make_res(KIND_NAME_CHAR, in_byte_reg, ERR_NONE);
                end else begin
                    r0 = make_res(KIND_NAME_END, CH_NUL, ERR_NONE);
                    if (in_eoi_reg) begin
                        mode_next = MODE_HALTED;
                        n_res     = 2'd2;
                        r1        = make_res(KIND_EOI, CH_NUL, ERR_NONE);
                    end else begin
                        mode_next = sb.mode;
                        n_res     = sb.emit ? 2'd2 : 2'd1;
                        r1        = sb.res;
                    end
                end
            end
            default: begin
                mode_next = MODE_HALTED;
            end
        endcase
        // Mark the final word caused by this byte.
        if (n_res == 2'd2) begin
            r1.last = 1'b1;
        end else if (n_res == 2'd1) begin
            r0.last = 1'b1;
        end
    end

    // Scanner state advances once per scanned byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BETWEEN;
            star_reg <= 1'b0;
        end else if (adv) begin
            mode_reg <= mode_next;
            star_reg <= star_next;
        end
    end

    // Result slots: slot0 is offered, slot1 waits behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (adv) begin
            cnt_reg <= n_res;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
        if (adv) begin
            slot0_reg <= r0;
            slot1_reg <= r1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    // Output word.
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {6'b000000, slot0_reg.err, slot0_reg.chr};
    assign m_tuser  = slot0_reg.kind;
    assign m_tlast  = slot0_reg.last;

    // Checks on slot bookkeeping and scanner state.
    `LTS_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    `LTS_ASSERT_ALWAYS(a_star_in_block, aclk, aresetn, !star_reg || (mode_reg == MODE_BLOCK))
    `LTS_ASSERT_NEXT(a_halt_silent, aclk, aresetn, adv && (mode_reg == MODE_HALTED), cnt_reg == 2'd0)
    `LTS_ASSERT_NEXT(a_error_halts, aclk, aresetn, adv && (n_res != 2'd0) && (r0.kind == KIND_ERROR), mode_reg == MODE_HALTED)

endmodule
